/* sv/accel_tilt_angle_defines.svh */
// ----------------------------------------------------------------------------
// accel_tilt_angle assertion macros
// clocked assertion helpers shared by the tilt angle block
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ACC_TILT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ACC_TILT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/acc_tilt_pkg.sv */
// ----------------------------------------------------------------------------
// acc_tilt_pkg
// shared widths, types, angle table and helpers of the tilt angle block
// ----------------------------------------------------------------------------
`default_nettype none

package acc_tilt_pkg;

    localparam int AXIS_W       = 16;
    localparam int SQUARE_W     = 2 * AXIS_W - 1;
    localparam int SQ_W         = 2 * AXIS_W;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = 32;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int CORDIC_ITERS = 25;
    localparam int XW           = 35;
    localparam int ZW           = 28;
    localparam int ZFRAC        = 12;
    localparam int QUARTER      = 9001;
    localparam int TILT_W       = 15;
    localparam int READY_W      = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;
    localparam int LANE_LAT     = 1 + SQRT_STEPS + CORDIC_ITERS + 1;

    // round(5730 * 4096 * atan(2^-i))
    localparam int ATAN_TAB [CORDIC_ITERS] = '{
        18433358, 10881846, 5749669, 2918622, 1464974, 733201, 366690, 183356,
        91680, 45840, 22920, 11460, 5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1
    };

    // axis side info carried along the root pipeline
    typedef struct packed {
        logic              neg;
        logic              a_zero;
        logic [AXIS_W-1:0] mag;
    } side_t;

    // special case flags carried along the cordic pipeline
    typedef struct packed {
        logic neg;
        logic a_zero;
        logic r_zero;
    } tflag_t;

    // arithmetic shift right, truncating toward zero
    function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                   input int unsigned s);
        logic [XW-1:0] m;
        logic [XW-1:0] q;
        m = v[XW-1] ? -v : v;
        q = m >> s;
        return v[XW-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

/* sv/acc_tilt_sqrt.sv */
// ----------------------------------------------------------------------------
// acc_tilt_sqrt
// pipelined digit-by-digit square root of sq * 2^32, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module acc_tilt_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [acc_tilt_pkg::SQ_W-1:0]     sq_in,
    input  wire acc_tilt_pkg::side_t               side_in,
    output logic      [acc_tilt_pkg::ROOT_W-1:0]   root_out,
    output acc_tilt_pkg::side_t                    side_out
);

    localparam int STEPS = acc_tilt_pkg::SQRT_STEPS;
    localparam int SQ_W  = acc_tilt_pkg::SQ_W;
    localparam int REM_W = acc_tilt_pkg::REM_W;
    localparam int RT_W  = acc_tilt_pkg::ROOT_W;

    logic [SQ_W-1:0]           sq_reg   [STEPS-1];
    logic [REM_W-1:0]          rem_reg  [STEPS-1];
    logic [RT_W-1:0]           root_reg [STEPS];
    acc_tilt_pkg::side_t       side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [SQ_W-1:0]     sq_cur;
        logic [REM_W-1:0]    rem_cur;
        logic [RT_W-1:0]     root_cur;
        acc_tilt_pkg::side_t side_cur;
        logic [REM_W+1:0]    acc;
        logic [RT_W+1:0]     trial;
        logic                ge;
        logic [RT_W-1:0]     root_next;

        if (k == 0) begin : g_first
            assign sq_cur   = sq_in;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
        end else begin : g_rest
            assign sq_cur   = sq_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        // bring down the next two radicand bits, try (root << 2) | 1
        assign acc       = {rem_cur, sq_cur[SQ_W-1 -: 2]};
        assign trial     = {root_cur, 2'b01};
        assign ge        = acc >= trial;
        assign root_next = {root_cur[RT_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_next;
                side_reg[k] <= side_cur;
            end
        end

        if (k < STEPS - 1) begin : g_carry
            logic [REM_W+1:0] diff;
            logic [SQ_W-1:0]  sq_next;
            logic [REM_W-1:0] rem_next;

            assign diff     = acc - trial;
            assign sq_next  = {sq_cur[SQ_W-3:0], 2'b00};
            assign rem_next = ge ? diff[REM_W-1:0] : acc[REM_W-1:0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_reg[k]  <= sq_next;
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign root_out = root_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];

endmodule

`default_nettype wire

/* sv/acc_tilt_cordic.sv */
// ----------------------------------------------------------------------------
// acc_tilt_cordic
// pipelined vectoring cordic, one micro-rotation per stage, angle in q12
// ----------------------------------------------------------------------------
`default_nettype none

module acc_tilt_cordic (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic        [acc_tilt_pkg::ROOT_W-1:0] root_in,
    input  wire acc_tilt_pkg::side_t                    side_in,
    output logic signed      [acc_tilt_pkg::ZW-1:0]     z_out,
    output acc_tilt_pkg::tflag_t                        flag_out
);

    localparam int ITERS  = acc_tilt_pkg::CORDIC_ITERS;
    localparam int XW     = acc_tilt_pkg::XW;
    localparam int ZW     = acc_tilt_pkg::ZW;
    localparam int RT_W   = acc_tilt_pkg::ROOT_W;
    localparam int AXIS_W = acc_tilt_pkg::AXIS_W;

    logic signed [XW-1:0]  x_reg    [ITERS-1];
    logic signed [XW-1:0]  y_reg    [ITERS-1];
    logic signed [ZW-1:0]  z_reg    [ITERS];
    acc_tilt_pkg::tflag_t  flag_reg [ITERS];

    acc_tilt_pkg::tflag_t  flag_in;

    assign flag_in.neg    = side_in.neg;
    assign flag_in.a_zero = side_in.a_zero;
    assign flag_in.r_zero = (root_in == '0);

    for (genvar i = 0; i < ITERS; i++) begin : g_iter
        logic signed [XW-1:0] x_cur;
        logic signed [XW-1:0] y_cur;
        logic signed [ZW-1:0] z_cur;
        acc_tilt_pkg::tflag_t flag_cur;
        logic                 pos;
        logic signed [ZW-1:0] z_next;

        if (i == 0) begin : g_first
            // x = root in q16, y = |a| in q16
            assign x_cur    = $signed({{(XW-RT_W){1'b0}}, root_in});
            assign y_cur    = $signed({{(XW-AXIS_W-16){1'b0}}, side_in.mag, 16'h0000});
            assign z_cur    = '0;
            assign flag_cur = flag_in;
        end else begin : g_rest
            assign x_cur    = x_reg[i-1];
            assign y_cur    = y_reg[i-1];
            assign z_cur    = z_reg[i-1];
            assign flag_cur = flag_reg[i-1];
        end

        assign pos    = !y_cur[XW-1] && (y_cur != '0);
        assign z_next = pos ? z_cur + ZW'(acc_tilt_pkg::ATAN_TAB[i])
                            : z_cur - ZW'(acc_tilt_pkg::ATAN_TAB[i]);

        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i]    <= z_next;
                flag_reg[i] <= flag_cur;
            end
        end

        if (i < ITERS - 1) begin : g_carry
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [XW-1:0] x_next;
            logic signed [XW-1:0] y_next;

            assign dx     = acc_tilt_pkg::shr_tz(y_cur, i);
            assign dy     = acc_tilt_pkg::shr_tz(x_cur, i);
            assign x_next = pos ? x_cur + dx : x_cur - dx;
            assign y_next = pos ? y_cur - dy : y_cur + dy;

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                end
            end
        end
    end

    assign z_out    = z_reg[ITERS-1];
    assign flag_out = flag_reg[ITERS-1];

endmodule

`default_nettype wire

/* sv/acc_tilt_lane.sv */
// ----------------------------------------------------------------------------
// acc_tilt_lane
// one tilt angle: square sum, root pipeline, cordic pipeline, rounding
// ----------------------------------------------------------------------------
`default_nettype none

module acc_tilt_lane (
    input  wire logic                                    aclk,
    input  wire logic                                    en,
    input  wire logic signed [acc_tilt_pkg::AXIS_W-1:0]  axis_a,
    input  wire logic        [acc_tilt_pkg::SQUARE_W-1:0] sq_b,
    input  wire logic        [acc_tilt_pkg::SQUARE_W-1:0] sq_c,
    output logic signed      [acc_tilt_pkg::TILT_W-1:0]  tilt
);

    localparam int AXIS_W = acc_tilt_pkg::AXIS_W;
    localparam int SQ_W   = acc_tilt_pkg::SQ_W;
    localparam int ZW     = acc_tilt_pkg::ZW;
    localparam int ZFRAC  = acc_tilt_pkg::ZFRAC;
    localparam int TW     = acc_tilt_pkg::TILT_W;
    localparam int HW     = ZW - ZFRAC;

    logic [SQ_W-1:0]                 sq_reg,   sq_next;
    acc_tilt_pkg::side_t             side_reg, side_next;
    logic [acc_tilt_pkg::ROOT_W-1:0] root;
    acc_tilt_pkg::side_t             side_root;
    logic signed [ZW-1:0]            z;
    acc_tilt_pkg::tflag_t            flag;
    logic signed [TW-1:0]            tilt_reg, tilt_next;

    logic [ZW-2:0]                   z_pos;
    logic [ZW-1:0]                   z_rnd;
    logic [HW-1:0]                   h;
    logic [TW-1:0]                   h_clamp;

    // square sum and axis magnitude
    assign sq_next          = {1'b0, sq_b} + {1'b0, sq_c};
    assign side_next.neg    = axis_a[AXIS_W-1];
    assign side_next.a_zero = (axis_a == '0);
    assign side_next.mag    = axis_a[AXIS_W-1] ? AXIS_W'(-axis_a) : AXIS_W'(axis_a);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_next;
            side_reg <= side_next;
        end
    end

    acc_tilt_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .sq_in    (sq_reg),
        .side_in  (side_reg),
        .root_out (root),
        .side_out (side_root)
    );

    acc_tilt_cordic u_cordic (
        .aclk     (aclk),
        .en       (en),
        .root_in  (root),
        .side_in  (side_root),
        .z_out    (z),
        .flag_out (flag)
    );

    // clamp at zero, round half up, clamp at a quarter turn
    assign z_pos   = z[ZW-1] ? '0 : z[ZW-2:0];
    assign z_rnd   = {1'b0, z_pos} + ZW'(1 << (ZFRAC - 1));
    assign h       = z_rnd[ZW-1:ZFRAC];
    assign h_clamp = (h > HW'(acc_tilt_pkg::QUARTER)) ? TW'(acc_tilt_pkg::QUARTER)
                                                     : h[TW-1:0];

    always_comb begin
        priority if (flag.a_zero) begin
            tilt_next = '0;
        end else if (flag.r_zero) begin
            tilt_next = flag.neg ? -$signed(TW'(acc_tilt_pkg::QUARTER))
                                 : $signed(TW'(acc_tilt_pkg::QUARTER));
        end else begin
            tilt_next = flag.neg ? -$signed(h_clamp) : $signed(h_clamp);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tilt_reg <= tilt_next;
        end
    end

    assign tilt = tilt_reg;

endmodule

`default_nettype wire

/* sv/accel_tilt_angle.sv */
// ----------------------------------------------------------------------------
// accel_tilt_angle
// three accelerometer tilt angles per sample in hundredths of a degree
// ----------------------------------------------------------------------------
// Takes one raw accelerometer sample per word and returns one result word
// per sample, in order. Each angle is atan2(a, sqrt(b^2 + c^2)) scaled by
// 5730, with a the axis and b, c the other two, rounded half away from zero
// and limited to +/-9001. A zero axis gives 0, a zero denominator gives
// +/-9001. When neither status bit in s_tuser is set the result word carries
// zero angles and valid_res low. Three identical lanes (one per axis) work
// side by side behind a shared squaring stage; each lane runs a 32-stage
// root pipeline (one root bit per stage) and a 25-stage vectoring cordic
// (one micro-rotation per stage). A new sample is taken every clock cycle
// while the pipeline is not stalled; each word passes the squaring stage,
// the lane and the output register. The pipeline moves as one; it stops
// only when its last stage holds a finished word and the output register
// still waits on m_tready, so samples keep entering while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_tilt_angle_defines.svh"

module accel_tilt_angle (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input words
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [acc_tilt_pkg::S_TDATA_W-1:0]    s_tdata,  // accel_x, accel_y, accel_z
    input  wire logic [acc_tilt_pkg::READY_W-1:0]      s_tuser,  // ready_bits
    // result words
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [acc_tilt_pkg::M_TDATA_W-1:0]    m_tdata,  // tilt_x, tilt_y, tilt_z, pad
    output logic      [acc_tilt_pkg::M_TUSER_W-1:0]    m_tuser   // valid_res
);

    localparam int AXIS_W   = acc_tilt_pkg::AXIS_W;
    localparam int SQUARE_W = acc_tilt_pkg::SQUARE_W;
    localparam int TW       = acc_tilt_pkg::TILT_W;
    localparam int PIPE_LAT = 1 + acc_tilt_pkg::LANE_LAT;
    localparam int PAD_W    = acc_tilt_pkg::M_TDATA_W - 3 * TW;

    // pipeline control
    logic                   take;        // output register free or being emptied
    logic                   en;          // whole pipeline advances
    logic [PIPE_LAT-1:0]    vld_reg,  vld_next;
    logic [PIPE_LAT-1:0]    rdy_reg,  rdy_next;

    // input fields
    logic signed [AXIS_W-1:0] in_x, in_y, in_z;

    // squaring stage
    logic signed [2*AXIS_W-1:0] prod_x, prod_y, prod_z;
    logic signed [AXIS_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [SQUARE_W-1:0]        sqx_reg, sqy_reg, sqz_reg;

    // lane results
    logic signed [TW-1:0]   lane_tx, lane_ty, lane_tz;

    // output register
    logic                   out_vld_reg, out_vld_next;
    logic signed [TW-1:0]   out_tx_reg, out_ty_reg, out_tz_reg;
    logic signed [TW-1:0]   out_tx_next, out_ty_next, out_tz_next;
    logic                   out_res_reg, out_res_next;

    assign in_x = $signed(s_tdata[AXIS_W-1:0]);
    assign in_y = $signed(s_tdata[2*AXIS_W-1:AXIS_W]);
    assign in_z = $signed(s_tdata[3*AXIS_W-1:2*AXIS_W]);

    // the pipe only stops when a finished word would hit a full output register
    assign take     = m_tready || !out_vld_reg;
    assign en       = take || !vld_reg[PIPE_LAT-1];
    assign s_tready = en;

    // valid and status flag travel beside the lanes
    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_tvalid};
    assign rdy_next = {rdy_reg[PIPE_LAT-2:0], (s_tuser != '0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rdy_reg <= rdy_next;
        end
    end

    // shared squares, one per axis
    assign prod_x = in_x * in_x;
    assign prod_y = in_y * in_y;
    assign prod_z = in_z * in_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= in_x;
            ay_reg  <= in_y;
            az_reg  <= in_z;
            sqx_reg <= prod_x[SQUARE_W-1:0];
            sqy_reg <= prod_y[SQUARE_W-1:0];
            sqz_reg <= prod_z[SQUARE_W-1:0];
        end
    end

    // one lane per axis: a over the root of the other two squares
    acc_tilt_lane u_lane_x (
        .aclk   (aclk),
        .en     (en),
        .axis_a (ax_reg),
        .sq_b   (sqy_reg),
        .sq_c   (sqz_reg),
        .tilt   (lane_tx)
    );

    acc_tilt_lane u_lane_y (
        .aclk   (aclk),
        .en     (en),
        .axis_a (ay_reg),
        .sq_b   (sqx_reg),
        .sq_c   (sqz_reg),
        .tilt   (lane_ty)
    );

    acc_tilt_lane u_lane_z (
        .aclk   (aclk),
        .en     (en),
        .axis_a (az_reg),
        .sq_b   (sqx_reg),
        .sq_c   (sqy_reg),
        .tilt   (lane_tz)
    );

    // merge: gate the three angles with the status flag
    assign out_vld_next = vld_reg[PIPE_LAT-1];
    assign out_res_next = rdy_reg[PIPE_LAT-1];
    assign out_tx_next  = rdy_reg[PIPE_LAT-1] ? lane_tx : '0;
    assign out_ty_next  = rdy_reg[PIPE_LAT-1] ? lane_ty : '0;
    assign out_tz_next  = rdy_reg[PIPE_LAT-1] ? lane_tz : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (take) begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && vld_reg[PIPE_LAT-1]) begin
            out_tx_reg  <= out_tx_next;
            out_ty_reg  <= out_ty_next;
            out_tz_reg  <= out_tz_next;
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_tz_reg, out_ty_reg, out_tx_reg};
    assign m_tuser  = out_res_reg;

    // no status bit means an all-zero word
    `ACC_TILT_ASSERT_IMP(a_zero_when_not_ready, m_tvalid && !m_tuser[0], m_tdata == '0, "angles nonzero without status")

    // every delivered angle stays within a quarter turn
    `ACC_TILT_ASSERT_IMP(a_angle_range, m_tvalid, ($signed(out_tx_reg) <= 15'sd9001) && ($signed(out_tx_reg) >= -15'sd9001) && ($signed(out_ty_reg) <= 15'sd9001) && ($signed(out_ty_reg) >= -15'sd9001) && ($signed(out_tz_reg) <= 15'sd9001) && ($signed(out_tz_reg) >= -15'sd9001), "angle out of range")

    // a stalled pipeline freezes the lane outputs
    `ACC_TILT_ASSERT_NXT(a_lane_hold, !s_tready, $stable(lane_tx) && $stable(lane_ty) && $stable(lane_tz), "lane moved while stalled")

    // an accepted word enters the first stage
    `ACC_TILT_ASSERT_NXT(a_enter, s_tvalid && s_tready, vld_reg[0], "accepted word lost at entry")

endmodule

`default_nettype wire
